// ===== sv/next_fit_heap_allocator_defines.svh =====
// Assertion helpers for the next-fit heap allocator. Both expect clk and rst in scope.
`ifndef NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define NFHA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nfha: same-cycle check failed");
`define NFHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfha: next-cycle check failed");
`else
`define NFHA_ASSERT_IMPL(label, ante, cons)
`define NFHA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/nfha_pkg.sv =====
package nfha_pkg;

  localparam int SIZE_W   = 13;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_ZERO,
    ST_NOFIT,
    ST_BADPTR,
    ST_NOTALLOC
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_SETUP,
    OP_RD_NFP,
    OP_RD_START,
    OP_A_STEP,
    OP_A_TAKE,
    OP_F_READ,
    OP_F_MARK,
    OP_M_SEED,
    OP_M_STEP,
    OP_M_LAST
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    set_res;
    status_t res;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic size_zero;
    logic init;
    logic bad_range;
    logic ent_start;
    logic ent_free;
    logic fit;
    logic a_nofit;
    logic chain_end;
    logic absorb;
  } dp_stat_t;

endpackage

// ===== sv/nfha_if.sv =====
interface nfha_req_if import nfha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  free_offset;
  logic              free_in_heap;

  modport source (output valid, func, request_size, free_offset, free_in_heap, input ready);
  modport sink   (input valid, func, request_size, free_offset, free_in_heap, output ready);
endinterface

interface nfha_rsp_if import nfha_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [OFF_W-1:0] payload_offset;

  modport source (output valid, status, payload_offset, input ready);
  modport sink   (input valid, status, payload_offset, output ready);
endinterface

// ===== sv/next_fit_heap_allocator.sv =====
// Next-fit heap allocator: keeps only the block headers (size, free flag,
// block-start mark) of a HEAP_BYTES byte heap in one header RAM and answers
// allocate and free requests with one result word each. After reset a clearing
// pass wipes the header RAM, during which no request is taken. An allocate
// visits headers in a next-fit walk (at most one lap of the chain); a free
// walks the whole chain from offset zero to merge runs of free blocks, with
// one more header write when the topmost run of free blocks merges. Each walk
// step is one read of the header RAM, so the RAM read port sets the pace. A
// finished word waits in the output register while the next request is taken.
module next_fit_heap_allocator import nfha_pkg::*; #(
  parameter int HEAP_BYTES      = 4096,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_SPLIT_BYTES = 8
) (
  input logic       clk,
  input logic       rst,
  nfha_req_if.sink  req,
  nfha_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nfha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  nfha_dp #(
    .HEAP_BYTES      (HEAP_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (req.func),
    .request_size   (req.request_size),
    .free_offset    (req.free_offset),
    .free_in_heap   (req.free_in_heap),
    .status         (rsp.status),
    .payload_offset (rsp.payload_offset)
  );

endmodule

// ===== sv/nfha_ram.sv =====
module nfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/nfha_dp.sv =====
`include "next_fit_heap_allocator_defines.svh"

module nfha_dp import nfha_pkg::*; #(
  parameter int HEAP_BYTES      = 4096,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_SPLIT_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              func,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [OFF_W-1:0]  free_offset,
  input  logic              free_in_heap,
  output status_t           status,
  output logic [OFF_W-1:0]  payload_offset
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
  localparam int EW = AW + 2;

  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] MIN_C  = CW'(MIN_SPLIT_BYTES);
  localparam logic [AW-1:0] SETUP_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(HEAP_BYTES - 1);

  // header store entry: {size, free, block start}
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  logic [AW-1:0] clr_addr;
  logic          init;
  logic [AW-1:0] nfp;

  logic              func_q;
  logic [SIZE_W-1:0] req_q;
  logic [OFF_W-1:0]  off_q;
  logic              inh_q;
  logic [AW-1:0]     rd_q;
  logic [AW-1:0]     start_pos;
  logic              wrapped;
  logic [AW-1:0]     at;
  logic [AW-1:0]     acc_size;
  logic              acc_free;
  logic              dirty;
  status_t           res_status;
  logic [OFF_W-1:0]  res_pay;
  status_t           status_q;
  logic [OFF_W-1:0]  pay_q;

  logic [AW-1:0] ent_size;
  logic          ent_free;
  logic          ent_start;
  logic [CW-1:0] ent_ext;
  logic [CW-1:0] req_ext;
  logic [CW-1:0] off_ext;
  logic [CW-1:0] nn_sum;
  logic [AW-1:0] nn;
  logic          chain_end;
  logic [AW-1:0] a_next;
  logic          lap_end;
  logic          fit;
  logic          split;
  logic          absorb;
  logic          bad_range;
  logic [AW-1:0] hdr;
  logic [AW-1:0] rest_addr;
  logic [AW-1:0] rest_size;
  logic [AW-1:0] acc_grow;
  logic [CW-1:0] pay_sum;

  nfha_ram #(.WIDTH(EW), .DEPTH(HEAP_BYTES)) u_hdr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign ent_size  = rd_data[EW-1:2];
  assign ent_free  = rd_data[1];
  assign ent_start = rd_data[0];
  assign ent_ext   = CW'(ent_size);
  assign req_ext   = CW'(req_q);
  assign off_ext   = CW'(off_q);

  // following header of the block just read
  assign nn_sum    = CW'(rd_q) + HDR_C + ent_ext;
  assign nn        = nn_sum[AW-1:0];
  assign chain_end = (nn_sum >= HEAP_C);
  assign a_next    = chain_end ? '0 : nn;
  assign lap_end   = chain_end ? (wrapped || (start_pos == '0))
                               : (wrapped && (nn == start_pos));

  assign fit   = ent_free && (ent_ext >= req_ext);
  assign split = (ent_ext >= req_ext + HDR_C + MIN_C);
  assign absorb = acc_free && ent_free;

  assign bad_range = !inh_q || (off_ext < HDR_C) || (off_ext >= HEAP_C);
  assign hdr       = AW'(off_ext - HDR_C);
  assign rest_addr = AW'(CW'(rd_q) + HDR_C + req_ext);
  assign rest_size = AW'(ent_ext - req_ext - HDR_C);
  assign acc_grow  = AW'(CW'(acc_size) + HDR_C + ent_ext);
  assign pay_sum   = CW'(rd_q) + HDR_C;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (cmd.op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      OP_SETUP: begin
        wr_en   = 1'b1;
        wr_data = {SETUP_SIZE, 1'b1, 1'b1};
      end
      OP_RD_NFP: begin
        rd_en   = 1'b1;
        rd_addr = nfp;
      end
      OP_RD_START: begin
        rd_en   = 1'b1;
        rd_addr = ent_start ? rd_q : '0;
      end
      OP_A_STEP: begin
        if (fit) begin
          if (split) begin
            wr_en   = 1'b1;
            wr_addr = rest_addr;
            wr_data = {rest_size, 1'b1, 1'b1};
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = a_next;
        end
      end
      OP_A_TAKE: begin
        wr_en   = 1'b1;
        wr_addr = rd_q;
        wr_data = {(split ? AW'(req_q) : ent_size), 1'b0, 1'b1};
      end
      OP_F_READ: begin
        rd_en   = !bad_range;
        rd_addr = hdr;
      end
      OP_F_MARK: begin
        wr_en   = 1'b1;
        wr_addr = rd_q;
        wr_data = {ent_size, 1'b1, 1'b1};
      end
      OP_M_SEED: begin
        rd_en = 1'b1;
      end
      OP_M_STEP: begin
        if (absorb) begin
          // absorbed header loses its start mark
          wr_en   = 1'b1;
          wr_addr = rd_q;
        end else if (dirty) begin
          wr_en   = 1'b1;
          wr_addr = at;
          wr_data = {acc_size, 1'b1, 1'b1};
        end
        rd_en   = !chain_end;
        rd_addr = nn;
      end
      OP_M_LAST: begin
        wr_en   = 1'b1;
        wr_addr = at;
        wr_data = {acc_size, 1'b1, 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      init     <= 1'b0;
      nfp      <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: clr_addr <= clr_addr + 1'b1;
        OP_SETUP: begin
          init <= 1'b1;
          nfp  <= '0;
        end
        OP_A_TAKE: nfp <= rd_q;
        OP_M_STEP: begin
          if (absorb && (nfp == rd_q)) begin
            nfp <= at;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= rd_addr;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res;
    end
    if (cmd.out_load) begin
      status_q <= res_status;
      pay_q    <= res_pay;
    end
    case (cmd.op)
      OP_LOAD: begin
        func_q  <= func;
        req_q   <= request_size;
        off_q   <= free_offset;
        inh_q   <= free_in_heap;
        res_pay <= '0;
      end
      OP_RD_START: begin
        start_pos <= ent_start ? rd_q : '0;
        wrapped   <= 1'b0;
      end
      OP_A_STEP: begin
        if (!fit && chain_end) begin
          wrapped <= 1'b1;
        end
      end
      OP_A_TAKE: res_pay <= pay_sum[OFF_W-1:0];
      OP_M_SEED: begin
        acc_free <= 1'b0;
        dirty    <= 1'b0;
      end
      OP_M_STEP: begin
        if (absorb) begin
          acc_size <= acc_grow;
          dirty    <= 1'b1;
        end else begin
          at       <= rd_q;
          acc_size <= ent_size;
          acc_free <= ent_free;
          dirty    <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.clr_last  = (clr_addr == LAST_ADDR);
    stat.is_free   = (func_q == FUNC_FREE);
    stat.size_zero = (req_q == '0);
    stat.init      = init;
    stat.bad_range = bad_range;
    stat.ent_start = ent_start;
    stat.ent_free  = ent_free;
    stat.fit       = fit;
    stat.a_nofit   = !fit && lap_end;
    stat.chain_end = chain_end;
    stat.absorb    = absorb;
  end

  assign status         = status_q;
  assign payload_offset = pay_q;

  `NFHA_ASSERT_IMPL(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr)
  `NFHA_ASSERT_IMPL(a_take_fits, cmd.op == OP_A_TAKE, fit && ent_start)

endmodule

// ===== sv/nfha_ctrl.sv =====
`include "next_fit_heap_allocator_defines.svh"

module nfha_ctrl import nfha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_SEED,
    S_START,
    S_A_STEP,
    S_A_TAKE,
    S_F_TEST,
    S_M_SEED,
    S_M_STEP,
    S_M_LAST,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NOP;
    cmd.set_res  = 1'b0;
    cmd.res      = ST_OK;
    cmd.out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.is_free) begin
          cmd.op = OP_F_READ;
          if (stat.bad_range) begin
            cmd.set_res = 1'b1;
            cmd.res     = ST_BADPTR;
            state_next  = S_DONE;
          end else begin
            state_next = S_F_TEST;
          end
        end else if (stat.size_zero) begin
          cmd.set_res = 1'b1;
          cmd.res     = ST_ZERO;
          state_next  = S_DONE;
        end else begin
          // first real allocate lays the heap out as one free block
          if (!stat.init) begin
            cmd.op = OP_SETUP;
          end
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd.op     = OP_RD_NFP;
        state_next = S_START;
      end
      S_START: begin
        cmd.op     = OP_RD_START;
        state_next = S_A_STEP;
      end
      S_A_STEP: begin
        cmd.op = OP_A_STEP;
        if (stat.fit) begin
          state_next = S_A_TAKE;
        end else if (stat.a_nofit) begin
          cmd.set_res = 1'b1;
          cmd.res     = ST_NOFIT;
          state_next  = S_DONE;
        end
      end
      S_A_TAKE: begin
        cmd.op      = OP_A_TAKE;
        cmd.set_res = 1'b1;
        cmd.res     = ST_OK;
        state_next  = S_DONE;
      end
      S_F_TEST: begin
        cmd.set_res = 1'b1;
        if (!stat.ent_start) begin
          cmd.res    = ST_BADPTR;
          state_next = S_DONE;
        end else if (stat.ent_free) begin
          cmd.res    = ST_NOTALLOC;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_F_MARK;
          cmd.res    = ST_OK;
          state_next = S_M_SEED;
        end
      end
      S_M_SEED: begin
        cmd.op     = OP_M_SEED;
        state_next = S_M_STEP;
      end
      S_M_STEP: begin
        cmd.op = OP_M_STEP;
        if (stat.chain_end) begin
          if (stat.absorb) begin
            state_next = S_M_LAST;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_M_LAST: begin
        cmd.op     = OP_M_LAST;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `NFHA_ASSERT_IMPL(a_load_into_free_slot, cmd.out_load, !out_valid || out_ready)
  `NFHA_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, state == S_CHK)
  `NFHA_ASSERT_IMPL(a_word_from_done, $rose(out_valid), $past(state == S_DONE))

endmodule

// ===== verif/next_fit_heap_allocator_tb.sv =====
`timescale 1ns / 1ps

module next_fit_heap_allocator_tb;
  import nfha_pkg::*;

  localparam int HEAP        = 4096;
  localparam int HDR         = 16;
  localparam int MIN_SPLIT   = 8;
  localparam int RAND_ITEMS  = 1530;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 600;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
    logic              in_heap;
  } heap_req_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] offset;
  } heap_word_t;

  typedef struct packed {
    heap_req_t  req;
    logic       typed;
    heap_word_t word;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // typed rows carry their reply; the others take the predictor's
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{FUNC_FREE,  13'd0,    12'd16,   1'b1}, 1'b1, '{ST_BADPTR,   12'd0}},
    '{'{FUNC_ALLOC, 13'd0,    12'hFFF,  1'b1}, 1'b1, '{ST_ZERO,     12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd16,   1'b0}, 1'b1, '{ST_BADPTR,   12'd0}},
    '{'{FUNC_ALLOC, 13'd4096, 12'd0,    1'b0}, 1'b1, '{ST_NOFIT,    12'd0}},
    '{'{FUNC_ALLOC, 13'd4080, 12'd0,    1'b0}, 1'b1, '{ST_OK,       12'd16}},
    '{'{FUNC_ALLOC, 13'd1,    12'hFFF,  1'b1}, 1'b1, '{ST_NOFIT,    12'd0}},
    '{'{FUNC_FREE,  13'h1FFF, 12'd16,   1'b1}, 1'b1, '{ST_OK,       12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd16,   1'b1}, 1'b1, '{ST_NOTALLOC, 12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd0,    1'b1}, 1'b1, '{ST_BADPTR,   12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd15,   1'b1}, 1'b1, '{ST_BADPTR,   12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd4095, 1'b1}, 1'b1, '{ST_BADPTR,   12'd0}},
    '{'{FUNC_ALLOC, 13'd1,    12'd0,    1'b0}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd20,   1'b1}, 1'b1, '{ST_BADPTR,   12'd0}},
    '{'{FUNC_ALLOC, 13'd4063, 12'd0,    1'b0}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd33,   1'b1}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd16,   1'b1}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_ALLOC, 13'd4057, 12'd0,    1'b0}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd16,   1'b1}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_ALLOC, 13'd4056, 12'd0,    1'b0}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_ALLOC, 13'd8,    12'd0,    1'b0}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_ALLOC, 13'd1,    12'd0,    1'b0}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd4088, 1'b1}, 1'b0, '{ST_OK,       12'd0}},
    '{'{FUNC_FREE,  13'd0,    12'd16,   1'b1}, 1'b0, '{ST_OK,       12'd0}}
  };

  logic clk;
  logic rst;

  nfha_req_if req ();
  nfha_rsp_if rsp ();

  next_fit_heap_allocator #(
    .HEAP_BYTES(HEAP),
    .HEADER_BYTES(HDR),
    .MIN_SPLIT_BYTES(MIN_SPLIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // shadow copy of the header store
  logic [OFF_W-1:0] hdr_size [HEAP];
  bit               hdr_free [HEAP];
  bit               hdr_mark [HEAP];
  bit               heap_set_up = 1'b0;
  int               cursor = 0;

  heap_word_t       due_replies [$];
  logic [OFF_W-1:0] live_ptrs [$];
  logic [OFF_W-1:0] freed_ptrs [$];

  int  errors = 0;
  int  n_alloc = 0;
  int  n_free = 0;
  int  status_seen [5] = '{0, 0, 0, 0, 0};
  bit  calm = 1'b0;
  int  hold_asks = 0;
  int  cycles = 0;

  function automatic int follow_hdr(input int at);
    int n;
    n = at + HDR + int'(hdr_size[at]);
    return (n >= HEAP) ? -1 : n;
  endfunction

  function automatic status_t heap_alloc(input int want, output logic [OFF_W-1:0] pay);
    int start, at, n, lap;
    bit wrapped;
    pay = '0;
    if (want == 0) return ST_ZERO;
    if (!heap_set_up) begin
      hdr_size[0] = OFF_W'(HEAP - HDR);
      hdr_free[0] = 1'b1;
      hdr_mark[0] = 1'b1;
      cursor      = 0;
      heap_set_up = 1'b1;
    end
    start   = hdr_mark[cursor] ? cursor : 0;
    at      = start;
    wrapped = 1'b0;
    for (lap = 0; lap < 2 * HEAP; lap++) begin
      if (hdr_free[at] && int'(hdr_size[at]) >= want) begin
        if (int'(hdr_size[at]) >= want + HDR + MIN_SPLIT) begin
          n           = at + HDR + want;
          hdr_size[n] = OFF_W'(int'(hdr_size[at]) - want - HDR);
          hdr_free[n] = 1'b1;
          hdr_mark[n] = 1'b1;
          hdr_size[at] = OFF_W'(want);
        end
        hdr_free[at] = 1'b0;
        cursor       = at;
        pay          = OFF_W'(at + HDR);
        return ST_OK;
      end
      n = follow_hdr(at);
      if (n < 0) begin
        if (wrapped) return ST_NOFIT;
        wrapped = 1'b1;
        at      = 0;
      end else begin
        at = n;
      end
      if (at == start && wrapped) return ST_NOFIT;
    end
    return ST_NOFIT;
  endfunction

  function automatic status_t heap_free(input logic [OFF_W-1:0] off, input logic in_heap);
    int hdr, at, n, guard;
    if (!in_heap || off < HDR) return ST_BADPTR;
    hdr = off - HDR;
    if (!hdr_mark[hdr]) return ST_BADPTR;
    if (hdr_free[hdr]) return ST_NOTALLOC;
    hdr_free[hdr] = 1'b1;
    // coalesce every run of free blocks from the bottom of the heap
    at    = 0;
    guard = 0;
    while (at >= 0 && guard < HEAP) begin
      guard++;
      if (hdr_free[at]) begin
        n = follow_hdr(at);
        while (n >= 0 && hdr_free[n] && guard < HEAP) begin
          guard++;
          hdr_size[at] = OFF_W'(int'(hdr_size[at]) + HDR + int'(hdr_size[n]));
          hdr_mark[n]  = 1'b0;
          if (cursor == n) cursor = at;
          n = follow_hdr(at);
        end
      end
      at = follow_hdr(at);
    end
    return ST_OK;
  endfunction

  function automatic heap_req_t pick_request();
    heap_req_t r;
    int        pick;
    bit        do_alloc;
    r.func         = FUNC_ALLOC;
    r.size         = SIZE_W'($urandom);
    r.offset       = OFF_W'($urandom);
    r.in_heap      = 1'($urandom);
    do_alloc = (live_ptrs.size() < 4) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 99) < 52);
    pick = $urandom_range(0, 99);
    if (do_alloc) begin
      if (pick < 3)       r.size = '0;
      else if (pick < 5) begin
        case ($urandom_range(0, 3))
          0:       r.size = 13'd4096;
          1:       r.size = 13'd4080;
          2:       r.size = 13'd4095;
          default: r.size = SIZE_W'($urandom_range(2048, 4096));
        endcase
      end
      else if (pick < 10) r.size = SIZE_W'($urandom_range(513, 4096));
      else if (pick < 30) r.size = SIZE_W'($urandom_range(65, 512));
      else                r.size = SIZE_W'($urandom_range(1, 64));
    end else begin
      r.func    = FUNC_FREE;
      r.in_heap = 1'b1;
      if (pick < 72 && live_ptrs.size() != 0)
        r.offset = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
      else if (pick < 80 && freed_ptrs.size() != 0)
        r.offset = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
      else if (pick < 86)
        r.offset = OFF_W'($urandom);
      else if (pick < 91)
        r.in_heap = 1'b0;
      else if (pick < 96 && live_ptrs.size() != 0)
        r.offset = OFF_W'(live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]
                          + $urandom_range(1, 7));
      else
        r.offset = OFF_W'($urandom_range(0, HDR - 1));
    end
    return r;
  endfunction

  task automatic send_word(input heap_req_t r, input bit typed, input heap_word_t typed_word);
    status_t          st;
    logic [OFF_W-1:0] pay;
    int               k;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.func         <= r.func;
    req.request_size <= r.size;
    req.free_offset  <= r.offset;
    req.free_in_heap <= r.in_heap;
    do @(posedge clk); while (!req.ready);

    if (r.func == FUNC_ALLOC) begin
      st = heap_alloc(int'(r.size), pay);
      n_alloc++;
    end else begin
      st  = heap_free(r.offset, r.in_heap);
      pay = '0;
      n_free++;
    end
    if (st == ST_OK) begin
      if (r.func == FUNC_ALLOC) begin
        live_ptrs.push_back(pay);
      end else begin
        for (k = 0; k < live_ptrs.size(); k++)
          if (live_ptrs[k] == r.offset) begin
            live_ptrs.delete(k);
            break;
          end
        freed_ptrs.push_back(r.offset);
        if (freed_ptrs.size() > 16) void'(freed_ptrs.pop_front());
      end
    end
    due_replies.push_back(typed ? typed_word : heap_word_t'{st, pay});
  endtask

  task automatic check_reply();
    heap_word_t want;
    if (due_replies.size() == 0) begin
      errors++;
      $display("%0t: reply word with nothing due: status %0d offset %0d",
               $time, rsp.status, rsp.payload_offset);
      return;
    end
    want = due_replies.pop_front();
    status_seen[int'(want.status)]++;
    if (rsp.status !== want.status) begin
      errors++;
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, want.status, rsp.status);
    end
    if (rsp.payload_offset !== want.offset) begin
      errors++;
      $display("%0t: payload_offset mismatch: expected %0d, actual %0d",
               $time, want.offset, rsp.payload_offset);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random back-pressure bursts, plus one long hold-off on request
  initial begin
    int stall_left, hold_left, hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp.valid && rsp.ready) check_reply();
        if (hold_left != 0) begin
          hold_left--;
          rsp.ready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
          hold_seen++;
          hold_left = LONG_HOLD - 1;
          rsp.ready <= 1'b0;
        end else if (stall_left != 0) begin
          stall_left--;
          rsp.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(0, 3);
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timed out after %0d cycles, %0d words still due",
             $time, cycles, due_replies.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int i;
    req.valid        <= 1'b0;
    req.func         <= FUNC_ALLOC;
    req.request_size <= '0;
    req.free_offset  <= '0;
    req.free_in_heap <= 1'b0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].word);

    // let the directed words drain before the random mix
    req.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    @(posedge clk);

    for (i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 600 && i < 750) || (i >= RAND_ITEMS - 150);
      if (i == 300) hold_asks++;
      if (i == 900) begin
        req.valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_word(pick_request(), 1'b0, heap_word_t'{ST_OK, OFF_W'(0)});
    end
    req.valid <= 1'b0;

    while (due_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d allocate, %0d free) in %0d cycles.",
             n_alloc + n_free, n_alloc, n_free, cycles);
    $display("Replies: ok %0d, zero size %0d, no fit %0d, bad pointer %0d, not allocated %0d.",
             status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_NOFIT],
             status_seen[ST_BADPTR], status_seen[ST_NOTALLOC]);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
